/* hw/rtl/alm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_pkg: shared definitions for the array linked list manager
// Pool geometry, field widths, command and result records, sequencer states
// and the link helpers used by the executor.
// ----------------------------------------------------------------------------
package alm_pkg;

	localparam int NODES       = 32;
	localparam int IDX_W       = $clog2(NODES);
	localparam int LINK_W      = $clog2(NODES + 1);
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(MAX_RESULTS);

	localparam int ACTION_W = 2;
	localparam int PRED_W   = 5;
	localparam int ID_W     = 32;
	localparam int GRADE_W  = 10;
	localparam int STATUS_W = 2;
	localparam int NIDX_W   = 5;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(NODES);

	localparam logic [ACTION_W-1:0] ACT_INSERT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DELETE   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TRAVERSE = 2'd2;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_DELETE,
		OP_TRAVERSE,
		OP_NONE
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_NO_SUCC = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_INS_RD,
		BS_INS_PRED,
		BS_INS_DONE,
		BS_DEL_PRED,
		BS_DEL_RD,
		BS_DEL_DONE,
		BS_TRV,
		BS_FAIL
	} bstate_t;

	typedef struct packed {
		op_t                 op;
		logic                at_head;
		logic [PRED_W-1:0]   pred;
		logic                pred_bad;
		logic [ID_W-1:0]     id;
		logic [GRADE_W-1:0]  grade;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [NIDX_W-1:0]   node_index;
		logic [ID_W-1:0]     node_id;
		logic [GRADE_W-1:0]  node_grade;
		logic [NIDX_W-1:0]   next_index;
		logic                next_is_nil;
		logic                last;
	} res_t;

	function automatic logic is_nil(logic [LINK_W-1:0] link);
		return link >= LINK_NIL;
	endfunction

	function automatic logic [IDX_W-1:0] link_idx(logic [LINK_W-1:0] link);
		return IDX_W'(link);
	endfunction

	function automatic logic [LINK_W-1:0] link_reset(logic [IDX_W-1:0] idx);
		logic [LINK_W-1:0] r;
		if (LINK_W'(idx) == LINK_W'(NODES - 1)) begin
			r = LINK_NIL;
		end else begin
			r = LINK_W'(idx) + LINK_W'(1);
		end
		return r;
	endfunction

	function automatic res_t make_res(logic [IDX_W-1:0] idx, logic [ID_W-1:0] id,
			logic [GRADE_W-1:0] grade, logic [LINK_W-1:0] link, logic last);
		res_t r;
		r.status      = STAT_OK;
		r.node_index  = NIDX_W'(idx);
		r.node_id     = id;
		r.node_grade  = grade;
		r.next_is_nil = is_nil(link);
		r.next_index  = is_nil(link) ? '0 : NIDX_W'(link);
		r.last        = last;
		return r;
	endfunction

endpackage

/* hw/rtl/alm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_in_if: request channel
// Valid/ready channel carrying one list action and its operands.
// ----------------------------------------------------------------------------
interface alm_in_if;
	import alm_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic                pred_is_head;
	logic [PRED_W-1:0]   pred_index;
	logic [ID_W-1:0]     student_id;
	logic [GRADE_W-1:0]  grade_tenths;

	modport source (
		output valid, action, pred_is_head, pred_index, student_id, grade_tenths,
		input  ready
	);

	modport sink (
		input  valid, action, pred_is_head, pred_index, student_id, grade_tenths,
		output ready
	);
endinterface

/* hw/rtl/alm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_out_if: result channel
// Valid/ready channel carrying one reported node or status per transfer.
// ----------------------------------------------------------------------------
interface alm_out_if;
	import alm_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [NIDX_W-1:0]   node_index;
	logic [ID_W-1:0]     node_id;
	logic [GRADE_W-1:0]  node_grade;
	logic [NIDX_W-1:0]   next_index;
	logic                next_is_nil;
	logic                last;

	modport source (
		output valid, status, node_index, node_id, node_grade, next_index,
		       next_is_nil, last,
		input  ready
	);

	modport sink (
		input  valid, status, node_index, node_id, node_grade, next_index,
		       next_is_nil, last,
		output ready
	);
endinterface

/* hw/rtl/array_linked_list_manager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_manager: linked list in a fixed node pool
// Keeps one singly linked list and one free list in a 32-node pool and
// carries out insert, delete and traverse requests.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue, so up to two can be taken while the
// executor is busy. The executor handles one request at a time, and its
// speed is set by the link memory, which has one write port and a
// registered read. Inserts and deletes after a predecessor read the
// predecessor's link before the update, a traversal reports one node per
// result, and a delete whose predecessor has no successor only reports a
// status. Each result is one transfer with last set on the final one, and
// the executor waits while the result register is still occupied.
module array_linked_list_manager (
	input  logic      clk,
	input  logic      arst_n,
	alm_in_if.sink    item,
	alm_out_if.source result
);
	import alm_pkg::*;

	logic cmd_vld;
	cmd_t cmd;
	logic cmd_pop;

	alm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cmd_vld (cmd_vld),
		.cmd     (cmd),
		.cmd_pop (cmd_pop)
	);

	alm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_vld (cmd_vld),
		.cmd     (cmd),
		.cmd_pop (cmd_pop),
		.result  (result)
	);
endmodule

/* hw/rtl/alm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_front: request decode and command queue
// Classifies each accepted request and holds it in a short queue until the
// executor takes it.
// ----------------------------------------------------------------------------
module alm_front (
	input  logic          clk,
	input  logic          arst_n,
	alm_in_if.sink        item,
	output logic          cmd_vld,
	output alm_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import alm_pkg::*;

	cmd_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              dec;
	logic              push;

	always_comb begin
		dec          = '0;
		dec.at_head  = item.pred_is_head;
		dec.pred     = item.pred_index;
		dec.pred_bad = 32'(item.pred_index) >= 32'(NODES);
		dec.id       = item.student_id;
		dec.grade    = item.grade_tenths;
		case (item.action)
			ACT_INSERT:   dec.op = OP_INSERT;
			ACT_DELETE:   dec.op = OP_DELETE;
			ACT_TRAVERSE: dec.op = OP_TRAVERSE;
			default:      dec.op = OP_NONE;
		endcase
	end

	assign item.ready = count_q != QCNT_W'(QDEPTH);
	assign push       = item.valid && item.ready;
	assign cmd_vld    = count_q != '0;
	assign cmd        = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && cmd_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= dec;
		end
	end
endmodule

/* hw/rtl/alm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_back: list executor
// Sequencer that owns the node pool memories and the list and free heads,
// carries out one command at a time and drives the registered result.
// ----------------------------------------------------------------------------
module alm_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_vld,
	input  alm_pkg::cmd_t cmd,
	output logic          cmd_pop,
	alm_out_if.source     result
);
	import alm_pkg::*;

	bstate_t            state_q;
	bstate_t            state_d;
	cmd_t               cmd_q;
	logic [IDX_W-1:0]   t_q;
	logic [LINK_W-1:0]  nxt_q;
	logic [CNT_W-1:0]   cnt_q;
	status_t            fail_q;
	status_t            fail_d;
	logic [LINK_W-1:0]  list_head_q;
	logic [LINK_W-1:0]  free_head_q;

	logic [LINK_W-1:0]  link_mem [NODES];
	logic [ID_W-1:0]    id_mem [NODES];
	logic [GRADE_W-1:0] grade_mem [NODES];
	logic [NODES-1:0]   link_vld_q;

	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   rd_addr_q;
	logic [LINK_W-1:0]  link_rdata_q;
	logic               link_vld_rd_q;
	logic [ID_W-1:0]    id_rdata_q;
	logic [GRADE_W-1:0] grade_rdata_q;
	logic [LINK_W-1:0]  link_rd;

	logic               link_we;
	logic [IDX_W-1:0]   link_wa;
	logic [LINK_W-1:0]  link_wd;
	logic               data_we;

	res_t               res_q;
	res_t               res_d;
	logic               res_vld_q;
	logic               res_ld;
	logic               can_load;
	logic               trv_last;
	logic [IDX_W-1:0]   pred_q;
	logic [IDX_W-1:0]   pred_head;
	logic [LINK_W-1:0]  ins_next;

	assign link_rd   = link_vld_rd_q ? link_rdata_q : link_reset(rd_addr_q);
	assign can_load  = !res_vld_q || result.ready;
	assign pred_q    = IDX_W'(cmd_q.pred);
	assign pred_head = IDX_W'(cmd.pred);
	assign trv_last  = is_nil(link_rd) || (cnt_q == CNT_W'(MAX_RESULTS - 1));
	assign ins_next  = cmd_q.at_head ? list_head_q :
	                   (pred_q == t_q) ? LINK_W'(t_q) : nxt_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (cmd_vld) begin
					case (cmd.op)
						OP_INSERT: begin
							if (is_nil(free_head_q) || (!cmd.at_head && cmd.pred_bad)) begin
								state_d = BS_FAIL;
							end else begin
								state_d = BS_INS_RD;
							end
						end
						OP_DELETE: begin
							if (is_nil(list_head_q) || (!cmd.at_head && cmd.pred_bad)) begin
								state_d = BS_FAIL;
							end else if (cmd.at_head) begin
								state_d = BS_DEL_RD;
							end else begin
								state_d = BS_DEL_PRED;
							end
						end
						OP_TRAVERSE: begin
							state_d = is_nil(list_head_q) ? BS_FAIL : BS_TRV;
						end
						default: state_d = BS_FAIL;
					endcase
				end
			end
			BS_INS_RD:   state_d = cmd_q.at_head ? BS_INS_DONE : BS_INS_PRED;
			BS_INS_PRED: state_d = BS_INS_DONE;
			BS_INS_DONE: state_d = can_load ? BS_IDLE : BS_INS_DONE;
			BS_DEL_PRED: state_d = is_nil(link_rd) ? BS_FAIL : BS_DEL_RD;
			BS_DEL_RD:   state_d = BS_DEL_DONE;
			BS_DEL_DONE: state_d = can_load ? BS_IDLE : BS_DEL_DONE;
			BS_TRV:      state_d = (can_load && trv_last) ? BS_IDLE : BS_TRV;
			BS_FAIL:     state_d = can_load ? BS_IDLE : BS_FAIL;
			default:     state_d = BS_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		rd_addr = t_q;
		link_we = 1'b0;
		link_wa = t_q;
		link_wd = nxt_q;
		data_we = 1'b0;
		res_ld  = 1'b0;
		res_d   = '0;
		fail_d  = STAT_NO_SUCC;
		case (state_q)
			BS_IDLE: begin
				cmd_pop = cmd_vld;
				case (cmd.op)
					OP_INSERT: begin
						rd_addr = link_idx(free_head_q);
						fail_d  = is_nil(free_head_q) ? STAT_FULL : STAT_NO_SUCC;
					end
					OP_DELETE: begin
						rd_addr = cmd.at_head ? link_idx(list_head_q) : pred_head;
						fail_d  = is_nil(list_head_q) ? STAT_EMPTY : STAT_NO_SUCC;
					end
					OP_TRAVERSE: begin
						rd_addr = link_idx(list_head_q);
						fail_d  = STAT_EMPTY;
					end
					default: fail_d = STAT_OK;
				endcase
			end
			BS_INS_RD: begin
				rd_addr = pred_q;
			end
			BS_INS_PRED: begin
				link_we = 1'b1;
				link_wa = t_q;
				link_wd = link_rd;
			end
			BS_INS_DONE: begin
				if (can_load) begin
					link_we = 1'b1;
					if (cmd_q.at_head) begin
						link_wa = t_q;
						link_wd = list_head_q;
					end else begin
						link_wa = pred_q;
						link_wd = LINK_W'(t_q);
					end
					data_we = 1'b1;
					res_ld  = 1'b1;
					res_d   = make_res(t_q, cmd_q.id, cmd_q.grade, ins_next, 1'b1);
				end
			end
			BS_DEL_PRED: begin
				rd_addr = link_idx(link_rd);
			end
			BS_DEL_RD: begin
				if (!cmd_q.at_head) begin
					link_we = 1'b1;
					link_wa = pred_q;
					link_wd = link_rd;
				end
			end
			BS_DEL_DONE: begin
				if (can_load) begin
					link_we = 1'b1;
					link_wa = t_q;
					link_wd = free_head_q;
					res_ld  = 1'b1;
					res_d   = make_res(t_q, id_rdata_q, grade_rdata_q, nxt_q, 1'b1);
				end
			end
			BS_TRV: begin
				if (can_load) begin
					res_ld = 1'b1;
					res_d  = make_res(t_q, id_rdata_q, grade_rdata_q, link_rd, trv_last);
					if (!trv_last) begin
						rd_addr = link_idx(link_rd);
					end
				end
			end
			BS_FAIL: begin
				if (can_load) begin
					res_ld       = 1'b1;
					res_d.status = fail_q;
					res_d.last   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			list_head_q <= LINK_NIL;
			free_head_q <= '0;
			link_vld_q  <= '0;
			res_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (link_we) begin
				link_vld_q[link_wa] <= 1'b1;
			end
			if (res_ld) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				BS_INS_RD: free_head_q <= link_rd;
				BS_INS_DONE: begin
					if (can_load && cmd_q.at_head) begin
						list_head_q <= LINK_W'(t_q);
					end
				end
				BS_DEL_RD: begin
					if (cmd_q.at_head) begin
						list_head_q <= link_rd;
					end
				end
				BS_DEL_DONE: begin
					if (can_load) begin
						free_head_q <= LINK_W'(t_q);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q  <= cmd;
			t_q    <= rd_addr;
			cnt_q  <= '0;
			fail_q <= fail_d;
		end
		case (state_q)
			BS_INS_PRED: nxt_q <= link_rd;
			BS_DEL_PRED: begin
				t_q    <= rd_addr;
				fail_q <= STAT_NO_SUCC;
			end
			BS_DEL_RD: nxt_q <= link_rd;
			BS_TRV: begin
				if (can_load && !trv_last) begin
					t_q   <= rd_addr;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (data_we) begin
			id_mem[t_q]    <= cmd_q.id;
			grade_mem[t_q] <= cmd_q.grade;
		end
		rd_addr_q     <= rd_addr;
		link_rdata_q  <= link_mem[rd_addr];
		link_vld_rd_q <= link_vld_q[rd_addr];
		id_rdata_q    <= id_mem[rd_addr];
		grade_rdata_q <= grade_mem[rd_addr];
	end

	assign result.valid       = res_vld_q;
	assign result.status      = res_q.status;
	assign result.node_index  = res_q.node_index;
	assign result.node_id     = res_q.node_id;
	assign result.node_grade  = res_q.node_grade;
	assign result.next_index  = res_q.next_index;
	assign result.next_is_nil = res_q.next_is_nil;
	assign result.last        = res_q.last;
endmodule
